// ===== rtl/sia_pkg.sv =====
// shared constants, opcodes and controller/datapath interface structs
// for the slot id allocator; no dependencies
`timescale 1ns / 1ps

package sia_pkg;

	localparam int TABLE_SIZE = 4096;
	localparam int ADDR_W     = $clog2(TABLE_SIZE);
	localparam int PTR_W      = ADDR_W + 1;
	localparam int ID_W       = 12;
	localparam int HANDLE_W   = 64;

	localparam logic [PTR_W-1:0] PTR_END = PTR_W'(TABLE_SIZE);

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic take;
		logic set_exh;
		logic advance;
		logic rd_ahead;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic need_scan;
		logic ptr_end;
		logic ahead_end;
		logic wrapped;
		logic slot_busy;
	} status_t;

endpackage

// ===== rtl/slot_id_allocator.sv =====
// slot id allocator: one request at a time, one response per request.
// release, kept id or refused add: idle accepts, then the result state hands off.
// new id: idle, scan, then once wrapped a check of the pointer slot and one more
// per occupied slot skipped, then result; the skip scan reads the occupancy memory
// one slot per cycle. response registered. async reset: table empty,
// next id 1, free mark at end, not exhausted; no clearing pass needed.
`timescale 1ns / 1ps

module slot_id_allocator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic                         opcode,
	input  logic [sia_pkg::HANDLE_W-1:0] handle,
	input  logic [sia_pkg::ID_W-1:0]     current_id,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [sia_pkg::ID_W-1:0]     assigned_id,
	output logic                         out_of_ids
);
	import sia_pkg::*;

	cmd_t    cmd;
	status_t status;

	sia_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd       (cmd)
	);

	sia_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.opcode      (opcode),
		.handle      (handle),
		.current_id  (current_id),
		.assigned_id (assigned_id),
		.out_of_ids  (out_of_ids)
	);

endmodule

// ===== rtl/sia_dp.sv =====
// datapath: slot occupancy memory, next pointer, free mark, exhausted flag
// and result register; depends on sia_pkg
`timescale 1ns / 1ps

module sia_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sia_pkg::cmd_t                cmd,
	output sia_pkg::status_t             status,
	input  logic                         opcode,
	input  logic [sia_pkg::HANDLE_W-1:0] handle,
	input  logic [sia_pkg::ID_W-1:0]     current_id,
	output logic [sia_pkg::ID_W-1:0]     assigned_id,
	output logic                         out_of_ids
);
	import sia_pkg::*;

	logic [PTR_W-1:0]  next_q;
	logic [PTR_W-1:0]  free_mark_q;
	logic [PTR_W-1:0]  next_inc;
	logic              exhausted_q;
	logic              wrapped_q;
	logic [ID_W-1:0]   given_q;
	logic [ID_W-1:0]   assigned_id_q;
	logic              out_of_ids_q;
	logic              busy_mem [TABLE_SIZE];
	logic              rd_data_q;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;
	logic              wr_data;
	logic              cur_zero;
	logic              rel_ok;
	logic              alloc_new;

	assign cur_zero  = current_id == '0;
	assign rel_ok    = opcode == OP_RELEASE && !cur_zero && (PTR_W'(current_id) < PTR_END);
	assign alloc_new = opcode == OP_ALLOC && cur_zero && !exhausted_q;
	assign next_inc  = next_q + PTR_W'(1);

	assign status.need_scan = alloc_new;
	assign status.ptr_end   = next_q >= PTR_END;
	assign status.ahead_end = next_inc >= PTR_END;
	assign status.wrapped   = wrapped_q;
	assign status.slot_busy = rd_data_q;

	// a zero handle leaves the slot reading as free
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = next_q[ADDR_W-1:0];
		wr_data = |handle;
		if (cmd.take && alloc_new) begin
			wr_en = 1'b1;
		end else if (cmd.take && rel_ok) begin
			wr_en   = 1'b1;
			wr_addr = ADDR_W'(current_id);
			wr_data = 1'b0;
		end
	end

	assign rd_addr = cmd.rd_ahead ? next_inc[ADDR_W-1:0] : next_q[ADDR_W-1:0];

	// before the first wrap no slot at or above the pointer was ever marked busy,
	// so the controller only reads the memory once wrapped is set
	always_ff @(posedge clk) begin
		if (wr_en) begin
			busy_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= busy_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_q      <= PTR_W'(1);
			free_mark_q <= PTR_END;
			exhausted_q <= 1'b0;
			wrapped_q   <= 1'b0;
		end else begin
			if (cmd.take && alloc_new) begin
				if (next_inc >= PTR_END) begin
					next_q    <= free_mark_q;
					wrapped_q <= 1'b1;
				end else begin
					next_q <= next_inc;
				end
			end else if (cmd.advance) begin
				next_q <= next_inc;
			end
			if (cmd.take && rel_ok && (PTR_W'(current_id) < free_mark_q)) begin
				free_mark_q <= PTR_W'(current_id);
			end
			if (cmd.set_exh) begin
				exhausted_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			if (opcode == OP_RELEASE) begin
				given_q <= '0;
			end else if (!cur_zero) begin
				given_q <= current_id;
			end else if (exhausted_q) begin
				given_q <= '0;
			end else begin
				given_q <= ID_W'(next_q);
			end
		end
		if (cmd.load_out) begin
			assigned_id_q <= given_q;
			out_of_ids_q  <= exhausted_q;
		end
	end

	assign assigned_id = assigned_id_q;
	assign out_of_ids  = out_of_ids_q;

`ifndef SYNTHESIS
	a_exh_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		exhausted_q |=> exhausted_q)
		else $error("exhausted flag cleared");

	a_next_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_q != '0)
		else $error("next pointer reached id zero");

	a_mark_down: assert property (@(posedge clk) disable iff (!arst_n)
		free_mark_q <= $past(free_mark_q))
		else $error("free mark increased");
`endif

endmodule

// ===== rtl/sia_ctrl.sv =====
// controller: request intake, skip scan sequencing and result handoff
// depends on sia_pkg
`timescale 1ns / 1ps

module sia_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	input  sia_pkg::status_t status,
	output sia_pkg::cmd_t    cmd
);
	import sia_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_CHECK  = 2'd2;
	localparam logic [1:0] ST_RESULT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       rsp_valid_q;
	logic       out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = state_q != ST_IDLE;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d  = status.need_scan ? ST_SCAN : ST_RESULT;
				end
			end
			ST_SCAN: begin
				// memory read of the pointer slot is issued here
				if (status.ptr_end) begin
					cmd.set_exh = 1'b1;
					state_d     = ST_RESULT;
				end else if (!status.wrapped) begin
					state_d = ST_RESULT;
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.slot_busy) begin
					cmd.advance = 1'b1;
					if (status.ahead_end) begin
						cmd.set_exh = 1'b1;
						state_d     = ST_RESULT;
					end else begin
						// read the slot the pointer advances to, ready for the next check
						cmd.rd_ahead = 1'b1;
					end
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_check_entry: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> ($past(state_q) == ST_SCAN || $past(state_q) == ST_CHECK))
		else $error("check state entered without a scan");

	a_result_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT && !rsp_valid_q) |=> (state_q == ST_IDLE && rsp_valid_q))
		else $error("result not handed off with free output");
`endif

endmodule
